[src/dsfp_pkg.sv]
// Shared types, codes and character helpers for the date string field parser.
// Depends on nothing; the step, top level and testbench import it.

package dsfp_pkg;

    localparam int DSFP_MAX_SEGMENTS = 8;
    localparam int LOOKAHEAD         = 4;
    localparam int CFG_W             = 24;
    localparam int FIELD_W           = 14;
    localparam int SMALL_W           = 7;
    localparam int NUM_FIELDS        = 6;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEPARATORS = 2'd0;
    localparam logic [1:0] REG_FIELDS     = 2'd1;
    localparam logic [1:0] REG_COUNT      = 2'd2;

    // Separator codes.
    localparam logic [2:0] SEP_SPACE = 3'd0;
    localparam logic [2:0] SEP_SLASH = 3'd1;
    localparam logic [2:0] SEP_DASH  = 3'd2;
    localparam logic [2:0] SEP_DOT   = 3'd3;
    localparam logic [2:0] SEP_COLON = 3'd4;

    // Field codes.
    localparam logic [2:0] FLD_NONE   = 3'd0;
    localparam logic [2:0] FLD_DAY    = 3'd1;
    localparam logic [2:0] FLD_MONTH  = 3'd2;
    localparam logic [2:0] FLD_YEAR   = 3'd3;
    localparam logic [2:0] FLD_HOUR   = 3'd4;
    localparam logic [2:0] FLD_MINUTE = 3'd5;
    localparam logic [2:0] FLD_SECOND = 3'd6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_SEP_MISMATCH  = 2'd1,
        ST_EMPTY_NUMBER  = 2'd2,
        ST_FMT_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        logic    skip;
        logic    stopped;
        status_t status;
    } dsfp_flags_t;

    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] record_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_SLASH) || (c == CH_DASH) ||
               (c == CH_DOT) || (c == CH_COLON);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Returns {usable, character}; codes above colon match nothing.
    function automatic logic [8:0] sep_char(input logic [2:0] code);
        logic [8:0] r;
        unique case (code)
            SEP_SPACE: r = {1'b1, CH_SPACE};
            SEP_SLASH: r = {1'b1, CH_SLASH};
            SEP_DASH:  r = {1'b1, CH_DASH};
            SEP_DOT:   r = {1'b1, CH_DOT};
            SEP_COLON: r = {1'b1, CH_COLON};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[src/dsfp_step.sv]
// One character decision of the parser: separator match, segment advance and
// number capture from the following characters. Depends on dsfp_pkg.

module dsfp_step
    import dsfp_pkg::*;
#(
    parameter int MAX_SEGMENTS = DSFP_MAX_SEGMENTS,
    localparam int IDX_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                              en,
    input  logic [7:0]                        cur_char,
    input  logic [LOOKAHEAD-1:0][7:0]         la_char,
    input  logic [LOOKAHEAD-1:0]              la_ok,
    input  logic [IDX_W-1:0]                  seg_limit,
    input  logic [CFG_W-1:0]                  seps,
    input  logic [CFG_W-1:0]                  flds,
    input  logic [IDX_W-1:0]                  idx_in,
    input  dsfp_flags_t                       flags_in,
    input  record_t                           rec_in,
    output logic [IDX_W-1:0]                  idx_out,
    output dsfp_flags_t                       flags_out,
    output record_t                           rec_out
);

    logic [4:0]         idx_ext;
    logic [2:0]         sep_code;
    logic [2:0]         fld_code;
    logic [8:0]         sep_info;
    logic [FIELD_W-1:0] val;
    logic               got;
    logic [2:0]         span;

    // Segments beyond the eighth read as space with no field.
    always_comb begin
        idx_ext = 5'(idx_in);
        if (idx_ext < 5'd8) begin
            sep_code = seps[{1'b0, idx_ext[2:0], 1'b0} + {2'b0, idx_ext[2:0]} +: 3];
            fld_code = flds[{1'b0, idx_ext[2:0], 1'b0} + {2'b0, idx_ext[2:0]} +: 3];
        end else begin
            sep_code = SEP_SPACE;
            fld_code = FLD_NONE;
        end
        sep_info = (idx_in == '0) ? {1'b1, CH_SPACE} : sep_char(sep_code);
    end

    always_comb begin
        span = (fld_code == FLD_YEAR) ? 3'd4 : 3'd2;
        val  = '0;
        got  = 1'b0;
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if ((3'(i) < span) && la_ok[i] && is_digit(la_char[i])) begin
                val = FIELD_W'(val * FIELD_W'(10)) + FIELD_W'(la_char[i] - CH_ZERO);
                got = 1'b1;
            end
        end
    end

    always_comb begin
        idx_out   = idx_in;
        flags_out = flags_in;
        rec_out   = rec_in;
        if (en) begin
            if (flags_in.skip) begin
                flags_out.skip = 1'b0;
            end else if (!flags_in.stopped && is_sep(cur_char)) begin
                if (idx_in >= seg_limit) begin
                    flags_out.stopped = 1'b1;
                    flags_out.status  = ST_FMT_EXHAUSTED;
                end else if (!sep_info[8] || (sep_info[7:0] != cur_char)) begin
                    flags_out.stopped = 1'b1;
                    flags_out.status  = ST_SEP_MISMATCH;
                end else begin
                    idx_out        = idx_in + IDX_W'(1);
                    flags_out.skip = 1'b1;
                    if ((fld_code >= FLD_DAY) && (fld_code <= FLD_SECOND)) begin
                        if (!got) begin
                            flags_out.stopped = 1'b1;
                            flags_out.status  = ST_EMPTY_NUMBER;
                        end else begin
                            rec_out[fld_code - FLD_DAY] = val;
                        end
                    end
                end
            end
        end
    end

endmodule

[src/date_string_field_parser.sv]
// The result beat is registered in the cycle after the tlast beat is accepted.
// One character beat per cycle, but a tlast beat waits while a result is held;
// the four-character window is decided in full in the cycle of the tlast beat.
// Reset (aresetn low, synchronous) clears the window, parse state and the
// result valid, and sets the format to one space segment with no field.
// Top level of the date string field parser; depends on dsfp_pkg, dsfp_step.

module date_string_field_parser
    import dsfp_pkg::*;
#(
    parameter int MAX_SEGMENTS = DSFP_MAX_SEGMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_char
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_value[6:0], month_value[13:7], year_value[27:14], hour_value[34:28],
    // minute_value[41:35], second_value[48:42], parse_status[50:49], zero fill
    output logic [55:0] m_tdata
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS + 1);
    localparam int BUF_N = LOOKAHEAD + 1;

    logic [CFG_W-1:0] seps_reg, flds_reg;
    logic [3:0]       count_reg;

    logic [LOOKAHEAD-1:0][7:0] win_reg;
    logic [2:0]                cnt_reg;
    logic                      started_reg;
    logic [IDX_W-1:0]          idx_reg;
    dsfp_flags_t               flags_reg;
    record_t                   rec_reg;

    logic                      m_tvalid_reg;
    logic [55:0]               m_tdata_reg;

    logic [BUF_N-1:0][7:0]     buf_c;
    logic [2:0]                n_c;
    logic [IDX_W-1:0]          seg_limit;
    logic                      s_accept;

    logic [IDX_W-1:0]          idx_c   [BUF_N+1];
    dsfp_flags_t               flags_c [BUF_N+1];
    record_t                   rec_c   [BUF_N+1];

    // A tlast beat needs the output register; other beats never do.
    assign s_tready = !m_tvalid_reg || m_tready || !s_tlast;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        if ({1'b0, count_reg} > 5'(MAX_SEGMENTS)) begin
            seg_limit = IDX_W'(MAX_SEGMENTS);
        end else begin
            seg_limit = IDX_W'(count_reg);
        end
    end

    // The first beat of a text is preceded by an implied space.
    always_comb begin
        buf_c = '0;
        if (!started_reg) begin
            buf_c[0] = CH_SPACE;
            buf_c[1] = s_tdata;
            n_c      = 3'd2;
        end else begin
            for (int j = 0; j < LOOKAHEAD; j++) begin
                if (3'(j) < cnt_reg) begin
                    buf_c[j] = win_reg[j];
                end
            end
            buf_c[cnt_reg] = s_tdata;
            n_c = cnt_reg + 3'd1;
        end
    end

    assign idx_c[0]   = idx_reg;
    assign flags_c[0] = flags_reg;
    assign rec_c[0]   = rec_reg;

    for (genvar k = 0; k < BUF_N; k++) begin : g_pos
        logic                      en;
        logic [LOOKAHEAD-1:0][7:0] la_char;
        logic [LOOKAHEAD-1:0]      la_ok;

        always_comb begin
            en = s_tlast ? (3'(k) < n_c) : ((k == 0) && (n_c == 3'(BUF_N)));
            la_char = '0;
            la_ok   = '0;
            for (int i = 0; i < LOOKAHEAD; i++) begin
                if (k + 1 + i < BUF_N) begin
                    la_char[i] = buf_c[k + 1 + i];
                    la_ok[i]   = 3'(k + 1 + i) < n_c;
                end
            end
        end

        dsfp_step #(
            .MAX_SEGMENTS(MAX_SEGMENTS)
        ) u_step (
            .en        (en),
            .cur_char  (buf_c[k]),
            .la_char   (la_char),
            .la_ok     (la_ok),
            .seg_limit (seg_limit),
            .seps      (seps_reg),
            .flds      (flds_reg),
            .idx_in    (idx_c[k]),
            .flags_in  (flags_c[k]),
            .rec_in    (rec_c[k]),
            .idx_out   (idx_c[k+1]),
            .flags_out (flags_c[k+1]),
            .rec_out   (rec_c[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seps_reg  <= '0;
            flds_reg  <= '0;
            count_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SEPARATORS: seps_reg  <= cfg_data;
                REG_FIELDS:     flds_reg  <= cfg_data;
                REG_COUNT:      count_reg <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
            flags_reg   <= '0;
            rec_reg     <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                win_reg     <= '0;
                cnt_reg     <= '0;
                started_reg <= 1'b0;
                idx_reg     <= '0;
                flags_reg   <= '0;
                rec_reg     <= '0;
            end else begin
                started_reg <= 1'b1;
                idx_reg     <= idx_c[BUF_N];
                flags_reg   <= flags_c[BUF_N];
                rec_reg     <= rec_c[BUF_N];
                if (n_c == 3'(BUF_N)) begin
                    win_reg <= buf_c[BUF_N-1:1];
                    cnt_reg <= 3'(LOOKAHEAD);
                end else begin
                    win_reg <= buf_c[LOOKAHEAD-1:0];
                    cnt_reg <= n_c;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept && s_tlast) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            m_tdata_reg <= {5'd0,
                            flags_c[BUF_N].status,
                            rec_c[BUF_N][5][SMALL_W-1:0],
                            rec_c[BUF_N][4][SMALL_W-1:0],
                            rec_c[BUF_N][3][SMALL_W-1:0],
                            rec_c[BUF_N][2],
                            rec_c[BUF_N][1][SMALL_W-1:0],
                            rec_c[BUF_N][0][SMALL_W-1:0]};
        end
    end

endmodule

[src/dsfp_checker.sv]
// Port-level checks for the date string field parser, bound to the top level.
// Depends only on the top level's ports.

module dsfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A result beat held back by the sink keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A new result only follows an accepted last character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a last character");

    // A character that is not last never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("result from a character that is not last");

    // Day and month stay below one hundred, the year below ten thousand.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'd99) && (m_tdata[13:7] <= 7'd99) &&
                     (m_tdata[27:14] <= 14'd9999))
        else $error("parsed value out of range");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind date_string_field_parser dsfp_checker u_dsfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/date_string_field_parser_tb.sv]
// Self-checking testbench for date_string_field_parser: directed texts, then random
// formats and mostly well-formed date texts, checked against typed or predicted records.
// Depends on dsfp_pkg and the date_string_field_parser RTL.
`timescale 1ns / 100ps

module date_string_field_parser_tb;
    import dsfp_pkg::*;

    localparam int N_DIRECTED    = 8;
    localparam int N_PHASES      = 16;
    localparam int PHASE_CHARS   = 105;
    localparam int EXTREME_CHARS = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        status_t     status;
    } date_record_t;

    typedef struct {
        logic [79:0]  txt;       // first character in the highest used byte
        int           len;
        logic         set_fmt;
        logic [23:0]  seps;
        logic [23:0]  flds;
        logic [3:0]   cnt;
        logic         typed;
        date_record_t res;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_SEPARATORS;
    logic [23:0] cfg_data = 24'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    date_string_field_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Format registers as the predictor sees them.
    logic [23:0] fmt_seps;
    logic [23:0] fmt_flds;
    logic [3:0]  fmt_count;

    // Parse state of the text in flight.
    logic [7:0]  held_chars[$];
    int          seg_idx;
    bit          skip_test;
    bit          started;
    bit          stopped;
    status_t     parse_st;
    logic [13:0] field_vals[6];

    date_record_t expected_dates[$];
    logic [7:0]   text_buf[$];
    int           fail_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_seq = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;

    function automatic logic [7:0] sep_of_code(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            SEP_SPACE: ch = CH_SPACE;
            SEP_SLASH: ch = CH_SLASH;
            SEP_DASH:  ch = CH_DASH;
            SEP_DOT:   ch = CH_DOT;
            SEP_COLON: ch = CH_COLON;
            default:   ch = 8'h00;   // never equal to a separator character
        endcase
        return ch;
    endfunction

    function automatic void clear_parse();
        held_chars.delete();
        seg_idx   = 0;
        skip_test = 1'b0;
        started   = 1'b0;
        stopped   = 1'b0;
        parse_st  = ST_OK;
        foreach (field_vals[i]) field_vals[i] = '0;
    endfunction

    function automatic void stop_parse(input status_t code);
        stopped  = 1'b1;
        parse_st = code;
    endfunction

    // Decides the oldest held character; the rest of the window is its lookahead.
    function automatic void decide_front();
        logic [7:0] c;
        logic [2:0] sep_code;
        logic [2:0] fld;
        int         seg_limit;
        int         span;
        int         val;
        int         got;
        c = held_chars[0];
        if (skip_test) begin
            skip_test = 1'b0;
            return;
        end
        if (stopped || !(c inside {CH_SPACE, CH_SLASH, CH_DASH, CH_DOT, CH_COLON}))
            return;
        seg_limit = (int'(fmt_count) > DSFP_MAX_SEGMENTS) ? DSFP_MAX_SEGMENTS : int'(fmt_count);
        if (seg_idx >= seg_limit) begin
            stop_parse(ST_FMT_EXHAUSTED);
            return;
        end
        sep_code = (seg_idx == 0) ? SEP_SPACE : fmt_seps[3*seg_idx +: 3];
        if (c != sep_of_code(sep_code)) begin
            stop_parse(ST_SEP_MISMATCH);
            return;
        end
        fld = fmt_flds[3*seg_idx +: 3];
        seg_idx++;
        skip_test = 1'b1;
        if (fld == FLD_NONE || fld > FLD_SECOND)
            return;
        span = (fld == FLD_YEAR) ? 4 : 2;
        val  = 0;
        got  = 0;
        for (int i = 1; i <= span; i++) begin
            if (i < held_chars.size() && held_chars[i] >= CH_ZERO && held_chars[i] <= CH_NINE) begin
                val = val * 10 + int'(held_chars[i] - CH_ZERO);
                got++;
            end
        end
        if (got == 0)
            stop_parse(ST_EMPTY_NUMBER);
        else
            field_vals[fld - 3'd1] = val[13:0];
    endfunction

    // Advances the parse by one accepted character; returns 1 when a record is due.
    function automatic bit predict_parse(input logic [7:0] c, input bit last,
                                         output date_record_t res);
        if (!started) begin
            held_chars.delete();
            held_chars.insert(held_chars.size(), CH_SPACE);
            started = 1'b1;
        end
        held_chars.insert(held_chars.size(), c);
        while (held_chars.size() == LOOKAHEAD + 1 || (last && held_chars.size() > 0)) begin
            decide_front();
            void'(held_chars.pop_front());
        end
        res = '{field_vals[0][6:0], field_vals[1][6:0], field_vals[2],
                field_vals[3][6:0], field_vals[4][6:0], field_vals[5][6:0], parse_st};
        if (!last)
            return 1'b0;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_date_beat();
        date_record_t want;
        if (expected_dates.size() == 0) begin
            $error("result beat with no record expected: tdata %h", m_tdata);
            fail_count++;
            return;
        end
        want = expected_dates.pop_front();
        compare_field("day_value",    int'(want.day),    int'(m_tdata[6:0]));
        compare_field("month_value",  int'(want.month),  int'(m_tdata[13:7]));
        compare_field("year_value",   int'(want.year),   int'(m_tdata[27:14]));
        compare_field("hour_value",   int'(want.hour),   int'(m_tdata[34:28]));
        compare_field("minute_value", int'(want.minute), int'(m_tdata[41:35]));
        compare_field("second_value", int'(want.second), int'(m_tdata[48:42]));
        compare_field("parse_status", int'(want.status), int'(m_tdata[50:49]));
    endfunction

    function automatic void random_format(output logic [23:0] seps, output logic [23:0] flds,
                                          output logic [3:0] cnt);
        for (int s = 0; s < 8; s++) begin
            seps[3*s +: 3] = ($urandom_range(99) < 90) ? 3'($urandom_range(4))
                                                       : 3'($urandom_range(7, 5));
            flds[3*s +: 3] = ($urandom_range(99) < 92) ? 3'($urandom_range(6)) : 3'd7;
        end
        cnt = ($urandom_range(99) < 85) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
    endfunction

    // Builds a text that follows the current format, with occasional damage or noise.
    function automatic void compose_date_text();
        int         nseg;
        int         span;
        int         ndig;
        logic [2:0] fld;
        logic [7:0] sep;
        text_buf.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(8, 1)) text_buf.insert(text_buf.size(), 8'($urandom));
            return;
        end
        nseg = (int'(fmt_count) > DSFP_MAX_SEGMENTS) ? DSFP_MAX_SEGMENTS : int'(fmt_count);
        if (nseg == 0)
            nseg = 1;
        for (int s = 0; s < nseg; s++) begin
            if (s > 0) begin
                sep = sep_of_code(fmt_seps[3*s +: 3]);
                if (sep == 8'h00)
                    sep = sep_of_code(3'($urandom_range(4)));
                text_buf.insert(text_buf.size(), sep);
            end
            fld  = fmt_flds[3*s +: 3];
            span = (fld == FLD_YEAR) ? 4 : 2;
            ndig = ($urandom_range(9) == 0) ? int'($urandom_range(span)) : span;
            for (int k = 0; k < ndig; k++)
                text_buf.insert(text_buf.size(), CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(9) == 0)
            text_buf.insert(text_buf.size(), sep_of_code(3'($urandom_range(4))));
        if ($urandom_range(9) == 0 && text_buf.size() > 0)
            text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom);
        if ($urandom_range(19) == 0 && text_buf.size() > 1)
            text_buf = text_buf[0 : $urandom_range(text_buf.size() - 2)];
        if (text_buf.size() == 0)
            text_buf.insert(text_buf.size(), 8'($urandom));
    endfunction

    task automatic send_beat(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input bit use_typed, input date_record_t typed_res);
        date_record_t predicted;
        bit           last;
        for (int i = 0; i < text_buf.size(); i++) begin
            last = (i == text_buf.size() - 1);
            send_beat(text_buf[i], last);
            if (predict_parse(text_buf[i], last, predicted)) begin
                if (use_typed)
                    expected_dates.insert(expected_dates.size(), typed_res);
                else
                    expected_dates.insert(expected_dates.size(), predicted);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_dates.size() != 0);
    endtask

    task automatic apply_format(input logic [23:0] seps, input logic [23:0] flds,
                                input logic [3:0] cnt);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SEPARATORS;
        cfg_data  <= seps;
        @(posedge aclk);
        cfg_index <= REG_FIELDS;
        cfg_data  <= flds;
        @(posedge aclk);
        cfg_index <= REG_COUNT;
        cfg_data  <= {20'd0, cnt};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fmt_seps  = seps;
        fmt_flds  = flds;
        fmt_count = cnt;
    endtask

    // Receiver side: checks every result beat and drives tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_date_beat();
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL date_string_field_parser");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        directed_row_t directed_rows[N_DIRECTED];
        date_record_t  unused_rec;
        logic [23:0]   seps;
        logic [23:0]   flds;
        logic [3:0]    cnt;
        int            phase_chars;
        int            phase_target;
        bit            pressed;

        unused_rec = '{7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 7'd0, ST_OK};
        fmt_seps  = 24'd0;
        fmt_flds  = 24'd0;
        fmt_count = 4'd1;
        clear_parse();

        // Reset format, then day/month/year, mismatch, no segments, all-ones registers,
        // empty number, separator as the last character, characters after a stop.
        directed_rows[0] = '{80'("A"), 1, 1'b0, 24'd0, 24'd0, 4'd1, 1'b1,
                             '{7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 7'd0, ST_OK}};
        directed_rows[1] = '{80'("99/00/9999"), 10, 1'b1,
                             {15'd0, SEP_SLASH, SEP_SLASH, SEP_SPACE},
                             {15'd0, FLD_YEAR, FLD_MONTH, FLD_DAY}, 4'd3, 1'b1,
                             '{7'd99, 7'd0, 14'd9999, 7'd0, 7'd0, 7'd0, ST_OK}};
        directed_rows[2] = '{80'("7-"), 2, 1'b0, 24'd0, 24'd0, 4'd0, 1'b1,
                             '{7'd7, 7'd0, 14'd0, 7'd0, 7'd0, 7'd0, ST_SEP_MISMATCH}};
        directed_rows[3] = '{80'(8'hFF), 1, 1'b1,
                             {15'd0, SEP_SLASH, SEP_SLASH, SEP_SPACE},
                             {15'd0, FLD_YEAR, FLD_MONTH, FLD_DAY}, 4'd0, 1'b1,
                             '{7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 7'd0, ST_FMT_EXHAUSTED}};
        directed_rows[4] = '{80'({8'h00, CH_SPACE}), 2, 1'b1, 24'hFFFFFF, 24'hFFFFFF,
                             4'd15, 1'b0, unused_rec};
        directed_rows[5] = '{80'("x"), 1, 1'b1, 24'd0, {21'd0, FLD_DAY}, 4'd1, 1'b1,
                             '{7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 7'd0, ST_EMPTY_NUMBER}};
        directed_rows[6] = '{80'("5:"), 2, 1'b1, {18'd0, SEP_COLON, SEP_SPACE},
                             {18'd0, FLD_MINUTE, FLD_HOUR}, 4'd2, 1'b0, unused_rec};
        directed_rows[7] = '{80'("ab.c.d"), 6, 1'b1, 24'd0, 24'd0, 4'd1, 1'b0, unused_rec};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].set_fmt)
                apply_format(directed_rows[r].seps, directed_rows[r].flds, directed_rows[r].cnt);
            text_buf.delete();
            for (int k = directed_rows[r].len - 1; k >= 0; k--)
                text_buf.insert(text_buf.size(), directed_rows[r].txt[8*k +: 8]);
            send_text(directed_rows[r].typed, directed_rows[r].res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                seps = 24'hFFFFFF;
                flds = 24'hFFFFFF;
                cnt  = 4'd15;
            end else if (p == 1) begin
                seps = 24'd0;
                flds = 24'd0;
                cnt  = 4'd0;
            end else begin
                random_format(seps, flds, cnt);
            end
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            apply_format(seps, flds, cnt);
            phase_target = (p < 2) ? EXTREME_CHARS : PHASE_CHARS;
            phase_chars  = 0;
            pressed      = 1'b0;
            while (phase_chars < phase_target) begin
                // Stall the receiver while short texts keep coming, so the block backs up
                // into its input; then let every pending record drain before going on.
                if ((p == 4 || p == 8) && !pressed && phase_chars >= phase_target / 2) begin
                    pressed  = 1'b1;
                    hold_seq = hold_seq + 1;
                    repeat (12) begin
                        text_buf.delete();
                        text_buf.insert(text_buf.size(), 8'($urandom));
                        send_text(1'b0, unused_rec);
                    end
                    wait_drained();
                end
                compose_date_text();
                phase_chars += text_buf.size();
                send_text(1'b0, unused_rec);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS date_string_field_parser");
        else
            $display("FAIL date_string_field_parser");
        $finish;
    end

endmodule
